// ===== rtl/core/checked_humidity_temperature_decode_assert.svh =====
// assertion macros for the checked humidity/temperature decoder
`ifndef CHECKED_HUMIDITY_TEMPERATURE_DECODE_ASSERT_SVH
`define CHECKED_HUMIDITY_TEMPERATURE_DECODE_ASSERT_SVH

// checked outside reset only
`define CHTD_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CHTD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/chtd_pkg.sv =====
// shared types, constants and crc function of the humidity/temperature decoder
package chtd_pkg;

  typedef enum logic [1:0] {
    POS_HIGH  = 2'd0,
    POS_LOW   = 2'd1,
    POS_CHECK = 2'd2
  } pos_t;

  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [15:0] STATUS_MASK = 16'hFFFC;
  localparam logic [14:0] TEMP_SCALE  = 15'd17572;
  localparam logic [14:0] RH_SCALE    = 15'd12500;
  localparam logic [15:0] TEMP_OFFSET = 16'd4685;
  localparam logic [15:0] RH_OFFSET   = 16'd600;

  typedef struct packed {
    logic signed [14:0] value_centi;
    logic [15:0]        raw_word;
  } chtd_result_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/chtd_convert.sv =====
// raw sensor word to signed hundredths conversion
module chtd_convert
  import chtd_pkg::*;
(
  input  logic [7:0]   high_byte,
  input  logic [7:0]   low_byte,
  input  logic         is_temperature,
  output chtd_result_t result
);

  logic [15:0] raw;
  logic [14:0] scale;
  logic [15:0] offset;
  logic [30:0] product;
  logic [15:0] value_wide;

  assign raw     = {high_byte, low_byte} & STATUS_MASK;
  assign scale   = is_temperature ? TEMP_SCALE : RH_SCALE;
  assign offset  = is_temperature ? TEMP_OFFSET : RH_OFFSET;
  assign product = {15'd0, raw} * {16'd0, scale};

  assign value_wide = {1'b0, product[30:16]} - offset;

  assign result.value_centi = signed'(value_wide[14:0]);
  assign result.raw_word    = raw;

endmodule

// ===== rtl/core/checked_humidity_temperature_decode.sv =====
// checked humidity/temperature decoder top level
//
// input beats carry one sensor byte each: data high, data low, then checksum.
// in_tuser[0] marks the first byte of a measurement and restarts the frame,
// in_tuser[1] tells temperature from humidity and is taken with the checksum.
// after the checksum byte one output beat comes out with the converted value
// in signed hundredths, the raw word with its status bits cleared, a crc-8
// (poly 0x31, init 0) error flag and the measurement kind; the first two
// bytes give no output beat.
// the checksum beat is first held in the input register, then its result is
// written to the output register, from which it can be taken.
// throughput: one byte per cycle unless out_tready stalls the output, set by
// the combinational crc and multiply between the input and output registers.
// reset clears the byte position, crc and both valid bits.
// when out_tready is low the result holds in the output register and the next
// byte still waits in the input register; in_tready then drops until the
// output register frees up.
module checked_humidity_temperature_decode
  import chtd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte[7:0]
  input  logic [1:0]  in_tuser,   // frame_start[0], is_temperature[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // value_centi[14:0], raw_word[30:15], zero[31]
  output logic [1:0]  out_tuser   // crc_error[0], was_temperature[1]
);

  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;
  logic         s1_start_r;
  logic         s1_temp_r;

  pos_t         pos_r, pos_nxt, pos_eff;
  logic [7:0]   high_r, high_nxt;
  logic [7:0]   low_r, low_nxt;
  logic [7:0]   crc_r, crc_nxt;
  logic         emit;

  logic         out_valid_r;
  chtd_result_t out_res_r;
  logic         out_crc_err_r;
  logic         out_temp_r;

  chtd_result_t conv_res;
  logic         advance;
  logic         step;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign step      = s1_valid_r && advance;
  assign pos_eff   = s1_start_r ? POS_HIGH : pos_r;

  // byte position
  always_comb begin
    case (pos_eff)
      POS_HIGH:  pos_nxt = POS_LOW;
      POS_LOW:   pos_nxt = POS_CHECK;
      POS_CHECK: pos_nxt = POS_HIGH;
      default:   pos_nxt = POS_LOW;
    endcase
  end

  // data bytes, crc and result strobe
  always_comb begin
    high_nxt = high_r;
    low_nxt  = low_r;
    crc_nxt  = crc_r;
    emit     = 1'b0;
    case (pos_eff)
      POS_HIGH: begin
        high_nxt = s1_byte_r;
        crc_nxt  = crc8_update(8'd0, s1_byte_r);
      end
      POS_LOW: begin
        low_nxt = s1_byte_r;
        crc_nxt = crc8_update(crc_r, s1_byte_r);
      end
      POS_CHECK: begin
        crc_nxt = 8'd0;
        emit    = 1'b1;
      end
      default: begin
        high_nxt = s1_byte_r;
        crc_nxt  = crc8_update(8'd0, s1_byte_r);
      end
    endcase
  end

  chtd_convert u_convert (
    .high_byte      (high_r),
    .low_byte       (low_r),
    .is_temperature (s1_temp_r),
    .result         (conv_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser[0];
      s1_temp_r  <= in_tuser[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_HIGH;
      high_r <= 8'd0;
      low_r  <= 8'd0;
      crc_r  <= 8'd0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      high_r <= high_nxt;
      low_r  <= low_nxt;
      crc_r  <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_res_r     <= conv_res;
      out_crc_err_r <= (crc_r != s1_byte_r);
      out_temp_r    <= s1_temp_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.raw_word, out_res_r.value_centi};
  assign out_tuser  = {out_temp_r, out_crc_err_r};

`include "checked_humidity_temperature_decode_assert.svh"

  `CHTD_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid_r, "output valid after reset")
  `CHTD_ASSERT_RUN(a_checksum_gives_beat, step && emit |=> out_valid_r, "checksum beat lost")
  `CHTD_ASSERT_RUN(a_stall_only_when_full, !in_tready |-> s1_valid_r && out_valid_r && !out_tready, "input stalled with room")

endmodule
